// ===== rtl/rtu_resync_ring_buffer_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RTU_RESYNC_RING_BUFFER_CORE_ASSERT_SVH
`define RTU_RESYNC_RING_BUFFER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RRB_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rrb_pkg.sv =====
`default_nettype none

package rrb_pkg;

   localparam int BUFFER_DEPTH_DEF = 256;
   localparam int MIN_FRAME_BYTES  = 4;

   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 3;
   localparam int CNT_W    = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] ADDR_MIN_RST = 8'd1;
   localparam logic [BYTE_W-1:0] ADDR_MAX_RST = 8'd247;

   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_MIN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_MAX = 1'd1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   localparam int RSP_FOUND_BIT = 0;
   localparam int RSP_POS_LSB   = 1;
   localparam int RSP_PVALID_BIT = 9;
   localparam int RSP_PBYTE_LSB = 10;
   localparam int RSP_FILL_LSB  = 18;
   localparam int RSP_TOTAL_LSB = 26;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_TOTAL_LSB - CNT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH        = 3'd0,
      CMD_DISCARD     = 3'd1,
      CMD_FIND        = 3'd2,
      CMD_PEEK        = 3'd3,
      CMD_CLEAR_STATS = 3'd4,
      CMD_RESET       = 3'd5
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/rtu_resync_ring_buffer_core.sv =====
// Path from acceptance to rsp_tvalid: S_EXEC then S_DONE for push, discard, clear_stats,
// reset, unused commands, an out-of-range peek and a find on fewer than 4 bytes; a peek
// passes S_PEEK and a find S_SCAN before S_DONE, which waits for a free output. S_SCAN reads
// from candidate to fill_level, one store entry per cycle through the single RAM read port.
// One transaction at a time: req_tready rises again once the result is registered.
// Reset (synchronous) clears pointers, candidate, counter, registers and handshakes, not the store.
`default_nettype none

module rtu_resync_ring_buffer_core #(
   parameter int BUFFER_DEPTH = rrb_pkg::BUFFER_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [7:0] data_byte, [15:8] count, [23:16] offset
   input  wire logic [rrb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [2:0] command
   input  wire logic [rrb_pkg::CMD_W-1:0]         req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] found, [8:1] position, [9] peek_valid, [17:10] peek_byte,
   // [25:18] fill_level, [57:26] discarded_total, [63:58] zero
   output logic      [rrb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_we,
   input  wire logic [rrb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rrb_pkg::BYTE_W-1:0]        csr_wdata
);

   import rrb_pkg::*;

   localparam int PW = $clog2(BUFFER_DEPTH);
   localparam int XW = (PW > BYTE_W) ? PW : BYTE_W;
   localparam logic [PW-1:0] LAST_IDX = PW'(BUFFER_DEPTH - 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_SCAN = 5'b00100,
      S_PEEK = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PW+1)'(BUFFER_DEPTH)) begin
         s = s - (PW+1)'(BUFFER_DEPTH);
      end
      return s[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [PW-1:0] v);
      logic [CNT_W:0] s;
      s = {1'b0, c} + (CNT_W+1)'(v);
      return s[CNT_W] ? '1 : s[CNT_W-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] low_byte(input logic [PW-1:0] v);
      logic [XW-1:0] t;
      t = XW'(v);
      return t[BYTE_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [BYTE_W-1:0]  data_ff, data_in;
   logic [BYTE_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0]  off_ff, off_in;
   logic [PW-1:0]      wp_ff, wp_in;
   logic [PW-1:0]      rp_ff, rp_in;
   logic [PW-1:0]      cand_ff, cand_in;
   logic [PW-1:0]      fill_ff, fill_in;
   logic [CNT_W-1:0]   drop_ff, drop_in;
   logic [BYTE_W-1:0]  amin_ff, amin_in;
   logic [BYTE_W-1:0]  amax_ff, amax_in;
   logic [PW-1:0]      scan_addr_ff, scan_addr_in;
   logic [PW-1:0]      issue_p_ff, issue_p_in;
   logic               cmp_valid_ff, cmp_valid_in;
   logic [PW-1:0]      cmp_p_ff, cmp_p_in;
   logic               found_ff, found_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic               pvalid_ff, pvalid_in;
   logic [BYTE_W-1:0]  pbyte_ff, pbyte_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               ram_we;
   logic               ram_re;
   logic [PW-1:0]      ram_raddr;
   logic [BYTE_W-1:0]  ram_rdata;

   logic [PW-1:0]      cnt_clamp;
   logic               off_ok;
   logic               rdata_match;
   logic               rsp_load;

   rrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (data_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign cnt_clamp   = (XW'(cnt_ff) > XW'(fill_ff)) ? fill_ff : PW'(cnt_ff);
   assign off_ok      = XW'(off_ff) < XW'(fill_ff);
   assign rdata_match = cmp_valid_ff && (ram_rdata >= amin_ff) && (ram_rdata <= amax_ff);
   assign rsp_load    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   assign ram_we    = (state_ff == S_EXEC) && (cmd_ff == CMD_PUSH);
   assign ram_re    = ((state_ff == S_EXEC) && (cmd_ff == CMD_PEEK)) ||
                      ((state_ff == S_SCAN) && (issue_p_ff < fill_ff));
   assign ram_raddr = (state_ff == S_EXEC) ? wrap_add(rp_ff, PW'(off_ff)) : scan_addr_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cand_in      = cand_ff;
      fill_in      = fill_ff;
      drop_in      = drop_ff;
      amin_in      = amin_ff;
      amax_in      = amax_ff;
      scan_addr_in = scan_addr_ff;
      issue_p_in   = issue_p_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_p_in     = cmp_p_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      pvalid_in    = pvalid_ff;
      pbyte_in     = pbyte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_we && (csr_index == CSR_ADDR_MIN)) begin
         amin_in = csr_wdata;
      end
      if (csr_we && (csr_index == CSR_ADDR_MAX)) begin
         amax_in = csr_wdata;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = cmd_type'(req_tuser);
               data_in  = req_tdata[7:0];
               cnt_in   = req_tdata[15:8];
               off_in   = req_tdata[23:16];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            found_in  = 1'b0;
            pos_in    = '0;
            pvalid_in = 1'b0;
            pbyte_in  = '0;
            state_in  = S_DONE;
            case (cmd_ff)
               CMD_PUSH: begin
                  wp_in = inc_ptr(wp_ff);
                  if (fill_ff == LAST_IDX) begin
                     rp_in   = inc_ptr(rp_ff);
                     drop_in = sat_add(drop_ff, PW'(1));
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
               CMD_DISCARD: begin
                  rp_in   = wrap_add(rp_ff, cnt_clamp);
                  fill_in = fill_ff - cnt_clamp;
                  drop_in = sat_add(drop_ff, cnt_clamp);
                  cand_in = (cand_ff >= cnt_clamp) ? cand_ff - cnt_clamp : '0;
               end
               CMD_FIND: begin
                  if (XW'(fill_ff) >= XW'(MIN_FRAME_BYTES)) begin
                     scan_addr_in = wrap_add(rp_ff, cand_ff);
                     issue_p_in   = cand_ff;
                     cmp_valid_in = 1'b0;
                     state_in     = S_SCAN;
                  end
               end
               CMD_PEEK: begin
                  if (off_ok) begin
                     state_in = S_PEEK;
                  end
               end
               CMD_CLEAR_STATS: begin
                  drop_in = '0;
               end
               CMD_RESET: begin
                  wp_in   = '0;
                  rp_in   = '0;
                  cand_in = '0;
                  fill_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_SCAN: begin
            if (rdata_match) begin
               found_in = 1'b1;
               pos_in   = cmp_p_ff;
               cand_in  = cmp_p_ff;
               state_in = S_DONE;
            end else if (issue_p_ff < fill_ff) begin
               scan_addr_in = inc_ptr(scan_addr_ff);
               issue_p_in   = issue_p_ff + 1'b1;
               cmp_p_in     = issue_p_ff;
               cmp_valid_in = 1'b1;
            end else begin
               cand_in  = '0;
               state_in = S_DONE;
            end
         end
         S_PEEK: begin
            pvalid_in = 1'b1;
            pbyte_in  = ram_rdata;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, drop_ff, low_byte(fill_ff), pbyte_ff,
                               pvalid_ff, low_byte(pos_ff), found_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cand_ff      <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         amin_ff      <= ADDR_MIN_RST;
         amax_ff      <= ADDR_MAX_RST;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cand_ff      <= cand_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         amin_ff      <= amin_in;
         amax_ff      <= amax_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      data_ff      <= data_in;
      cnt_ff       <= cnt_in;
      off_ff       <= off_in;
      scan_addr_ff <= scan_addr_in;
      issue_p_ff   <= issue_p_in;
      cmp_p_ff     <= cmp_p_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      pvalid_ff    <= pvalid_in;
      pbyte_ff     <= pbyte_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/rrb_ram.sv =====
`default_nettype none

module rrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rrb_checker.sv =====
`default_nettype none
`include "rtu_resync_ring_buffer_core_assert.svh"

module rrb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [rrb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import rrb_pkg::*;

   `RRB_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response transaction changed")

   `RRB_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "request accepted while a transaction is in work")

   `RRB_ASSERT_NOW(a_find_peek_excl, rsp_tvalid, !(rsp_tdata[RSP_FOUND_BIT] && rsp_tdata[RSP_PVALID_BIT]), "found and peek_valid both set")

   `RRB_ASSERT_NOW(a_zero_fields, rsp_tvalid, (rsp_tdata[RSP_PVALID_BIT] || (rsp_tdata[RSP_PBYTE_LSB +: 8] == 8'd0)) && (rsp_tdata[RSP_FOUND_BIT] || (rsp_tdata[RSP_POS_LSB +: 8] == 8'd0)), "position or peek_byte nonzero without a hit")

endmodule

bind rtu_resync_ring_buffer_core rrb_checker u_rrb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
